>>> rtl/core/tsa_pkg.sv
// Shared types and constants of the tick scheduler with timeout alarms.
package tsa_pkg;

	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ARM    = 3'd1;
	localparam logic [2:0] OP_DISARM = 3'd2;
	localparam logic [2:0] OP_LOAD   = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [1:0] KIND_MSG   = 2'd0;
	localparam logic [1:0] KIND_ALARM = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [2:0] SECONDS_CH = 3'd6;

	localparam logic [3:0] TICK_DEST = 4'd1;
	localparam logic [1:0] TICK_CMD  = 2'd0;

	localparam logic [7:0]  HUNDRED       = 8'd100;
	localparam logic [9:0]  THREE_HUNDRED = 10'd300;
	localparam logic [9:0]  FIVE_HUNDRED  = 10'd500;
	localparam logic [10:0] THOUSAND      = 11'd1000;

	localparam logic [2:0] STEP_A    = 3'd2;
	localparam logic [2:0] STEP_B    = 3'd3;
	localparam logic [2:0] STEP_C    = 3'd4;
	localparam logic [2:0] STEP_LAST = 3'd6;
	localparam logic [1:0] STEP_CMD_A    = 2'd0;
	localparam logic [1:0] STEP_CMD_B    = 2'd1;
	localparam logic [1:0] STEP_CMD_C    = 2'd0;
	localparam logic [1:0] STEP_CMD_LAST = 2'd2;

	// Fixed message slots after the alarm slots, in delivery order.
	localparam int FIX_SLOTS = 9;
	localparam logic [3:0] STEP_SLOT = 4'd1;
	localparam logic [3:0] FIX_DEST [FIX_SLOTS] = '{
		4'd6, 4'd7, 4'd2, 4'd8, 4'd3, 4'd10, 4'd13, 4'd6, 4'd12
	};
	localparam logic [1:0] FIX_CMD [FIX_SLOTS] = '{
		2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
	};

	// Base slot, fixed slots and read slot beside the alarm slots.
	localparam int EXTRA_SLOTS = FIX_SLOTS + 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPW         = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [2:0]  operation;
		logic [2:0]  channel;
		logic [15:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  destination;
		logic [1:0]  command;
		logic [2:0]  alarm_channel;
		logic [31:0] read_value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]  step_cmd;
		logic [2:0]  rd_ch;
		logic [31:0] rd_val;
	} job_info_t;

	function automatic logic narrow_ctr(input int idx);
		return (idx >= 1) && (idx <= 3);
	endfunction

endpackage

>>> rtl/core/tsa_front.sv
// Front end: accepts items, updates scheduler state and builds result jobs.
module tsa_front #(
	parameter int A  = 4,
	parameter int F  = 6,
	parameter int NS = A + tsa_pkg::EXTRA_SLOTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  tsa_pkg::item_t      item,
	input  logic                full,
	output logic                push,
	output logic [NS-1:0]       push_pend,
	output tsa_pkg::job_info_t  push_info
);

	localparam int AIW = (A > 1) ? $clog2(A) : 1;
	localparam int CIW = (F > 1) ? $clog2(F) : 1;
	localparam logic [3:0] A_LIM = 4'(A);
	localparam logic [3:0] F_LIM = 4'(F);

	logic [7:0]  cnt_q   [A];
	logic [7:0]  lim_q   [A];
	logic [A-1:0] armed_q;
	logic [15:0] fc_q    [F];
	logic [6:0]  dh_q;
	logic [8:0]  d3_q;
	logic [8:0]  d5_q;
	logic [9:0]  dk_q;
	logic [2:0]  step_q;
	logic [31:0] sec_q;

	logic [7:0]  cnt_d   [A];
	logic [7:0]  lim_d   [A];
	logic [A-1:0] armed_d;
	logic [15:0] fc_d    [F];
	logic [6:0]  dh_d;
	logic [8:0]  d3_d;
	logic [8:0]  d5_d;
	logic [9:0]  dk_d;
	logic [2:0]  step_d;
	logic [31:0] sec_d;

	logic          accept;
	logic [NS-1:0] pend;
	tsa_pkg::job_info_t info;
	logic [7:0]    inc;
	logic [7:0]    h_n;
	logic [9:0]    t_n;
	logic [9:0]    f_n;
	logic [10:0]   k_n;
	logic [2:0]    s_n;
	logic          a_ok;
	logic          c_ok;
	logic [AIW-1:0] ach;
	logic [CIW-1:0] cch;

	assign item_stall = full;
	assign accept     = item_valid && !full;
	assign a_ok       = {1'b0, item.channel} < A_LIM;
	assign c_ok       = {1'b0, item.channel} < F_LIM;
	assign ach        = item.channel[AIW-1:0];
	assign cch        = item.channel[CIW-1:0];

	always_comb begin
		cnt_d   = cnt_q;
		lim_d   = lim_q;
		armed_d = armed_q;
		fc_d    = fc_q;
		dh_d    = dh_q;
		d3_d    = d3_q;
		d5_d    = d5_q;
		dk_d    = dk_q;
		step_d  = step_q;
		sec_d   = sec_q;
		pend    = '0;
		info    = '0;
		inc     = '0;
		s_n     = '0;
		h_n     = {1'b0, dh_q} + 8'd1;
		t_n     = {1'b0, d3_q} + 10'd1;
		f_n     = {1'b0, d5_q} + 10'd1;
		k_n     = {1'b0, dk_q} + 11'd1;
		unique case (item.operation)
			tsa_pkg::OP_TICK: begin
				pend[0] = 1'b1;
				for (int i = 0; i < F; i++) begin
					if (tsa_pkg::narrow_ctr(i)) begin
						fc_d[i] = {8'd0, fc_q[i][7:0] + 8'd1};
					end else begin
						fc_d[i] = fc_q[i] + 16'd1;
					end
				end
				for (int i = 0; i < A; i++) begin
					if (armed_q[i]) begin
						inc      = cnt_q[i] + 8'd1;
						cnt_d[i] = inc;
						if (inc > lim_q[i]) begin
							pend[1 + i] = 1'b1;
							armed_d[i]  = 1'b0;
						end
					end
				end
				if (h_n >= tsa_pkg::HUNDRED) begin
					dh_d        = '0;
					pend[A + 1] = 1'b1;
					s_n         = step_q + 3'd1;
					case (s_n)
						tsa_pkg::STEP_A: begin
							pend[A + 2]   = 1'b1;
							info.step_cmd = tsa_pkg::STEP_CMD_A;
						end
						tsa_pkg::STEP_B: begin
							pend[A + 2]   = 1'b1;
							info.step_cmd = tsa_pkg::STEP_CMD_B;
						end
						tsa_pkg::STEP_C: begin
							pend[A + 2]   = 1'b1;
							info.step_cmd = tsa_pkg::STEP_CMD_C;
						end
						tsa_pkg::STEP_LAST: begin
							pend[A + 2]   = 1'b1;
							info.step_cmd = tsa_pkg::STEP_CMD_LAST;
							s_n           = '0;
						end
						default: ;
					endcase
					step_d = s_n;
				end else begin
					dh_d = h_n[6:0];
				end
				if (t_n >= tsa_pkg::THREE_HUNDRED) begin
					d3_d        = '0;
					pend[A + 3] = 1'b1;
					pend[A + 4] = 1'b1;
				end else begin
					d3_d = t_n[8:0];
				end
				if (f_n >= tsa_pkg::FIVE_HUNDRED) begin
					d5_d        = '0;
					pend[A + 5] = 1'b1;
					pend[A + 6] = 1'b1;
					pend[A + 7] = 1'b1;
				end else begin
					d5_d = f_n[8:0];
				end
				if (k_n >= tsa_pkg::THOUSAND) begin
					dk_d        = '0;
					sec_d       = sec_q + 32'd1;
					pend[A + 8] = 1'b1;
					pend[A + 9] = 1'b1;
				end else begin
					dk_d = k_n[9:0];
				end
			end
			tsa_pkg::OP_ARM: begin
				if (a_ok) begin
					cnt_d[ach]   = '0;
					lim_d[ach]   = item.value[7:0];
					armed_d[ach] = 1'b1;
				end
			end
			tsa_pkg::OP_DISARM: begin
				if (a_ok) begin
					armed_d[ach] = 1'b0;
				end
			end
			tsa_pkg::OP_LOAD: begin
				if (c_ok && item.channel != tsa_pkg::SECONDS_CH) begin
					if (item.channel <= 3'd3) begin
						fc_d[cch] = {8'd0, item.value[7:0]};
					end else begin
						fc_d[cch] = item.value;
					end
				end
			end
			tsa_pkg::OP_READ: begin
				pend[NS - 1] = 1'b1;
				info.rd_ch   = item.channel;
				if (item.channel == tsa_pkg::SECONDS_CH) begin
					info.rd_val = sec_q;
				end else if (c_ok) begin
					info.rd_val = {16'd0, fc_q[cch]};
				end
			end
			default: ;
		endcase
	end

	assign push      = accept && (pend != '0);
	assign push_pend = pend;
	assign push_info = info;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < A; i++) begin
				cnt_q[i] <= '0;
				lim_q[i] <= '0;
			end
			for (int i = 0; i < F; i++) begin
				fc_q[i] <= '0;
			end
			armed_q <= '0;
			dh_q    <= '0;
			d3_q    <= '0;
			d5_q    <= '0;
			dk_q    <= '0;
			step_q  <= '0;
			sec_q   <= '0;
		end else if (accept) begin
			cnt_q   <= cnt_d;
			lim_q   <= lim_d;
			armed_q <= armed_d;
			fc_q    <= fc_d;
			dh_q    <= dh_d;
			d3_q    <= d3_d;
			d5_q    <= d5_d;
			dk_q    <= dk_d;
			step_q  <= step_d;
			sec_q   <= sec_d;
		end
	end

endmodule

>>> rtl/core/tsa_queue.sv
// Short job queue between the front end and the result sequencer.
module tsa_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         head_valid,
	output logic [W-1:0] head_data,
	output logic         full
);

	logic [W-1:0]                  slot_q [tsa_pkg::QUEUE_DEPTH];
	logic [tsa_pkg::QPW-1:0]       wr_q;
	logic [tsa_pkg::QPW-1:0]       rd_q;
	logic [tsa_pkg::QPW:0]         count_q;

	localparam logic [tsa_pkg::QPW:0] DEPTH_C = (tsa_pkg::QPW + 1)'(tsa_pkg::QUEUE_DEPTH);

	assign head_valid = count_q != '0;
	assign head_data  = slot_q[rd_q];
	assign full       = count_q == DEPTH_C;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/tsa_back.sv
// Back end: walks a job's pending results and delivers one per transfer.
module tsa_back #(
	parameter int A  = 4,
	parameter int NS = A + tsa_pkg::EXTRA_SLOTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  logic [NS-1:0]       job_pend,
	input  tsa_pkg::job_info_t  job_info,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output tsa_pkg::result_t    result
);

	localparam int SW = $clog2(NS);
	localparam logic [SW-1:0] ONE_S  = SW'(1);
	localparam logic [SW-1:0] FIX_LO = SW'(A + 1);
	localparam logic [SW-1:0] ALM_HI = SW'(A);
	localparam logic [SW-1:0] RD_S   = SW'(NS - 1);

	logic               busy_q;
	logic [NS-1:0]      pend_q;
	tsa_pkg::job_info_t info_q;
	logic               rv_q;
	tsa_pkg::result_t   res_q;

	logic [NS-1:0]      low;
	logic [NS-1:0]      rest;
	logic [SW-1:0]      idx;
	logic [SW-1:0]      fidx;
	logic [3:0]         f;
	logic               advance;
	logic               emit;
	tsa_pkg::result_t   res_d;

	assign low     = pend_q & (~pend_q + 1'b1);
	assign rest    = pend_q & ~low;
	assign advance = !rv_q || !result_stall;
	assign emit    = busy_q && advance;
	assign pop     = job_valid && (!busy_q || (emit && rest == '0));

	always_comb begin
		idx = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				idx = SW'(i);
			end
		end
	end

	assign fidx = idx - FIX_LO;
	assign f    = 4'(fidx);

	always_comb begin
		res_d      = '0;
		res_d.last = rest == '0;
		if (idx == '0) begin
			res_d.kind        = tsa_pkg::KIND_MSG;
			res_d.destination = tsa_pkg::TICK_DEST;
			res_d.command     = tsa_pkg::TICK_CMD;
		end else if (idx <= ALM_HI) begin
			res_d.kind          = tsa_pkg::KIND_ALARM;
			res_d.alarm_channel = 3'(idx - ONE_S);
		end else if (idx == RD_S) begin
			res_d.kind          = tsa_pkg::KIND_READ;
			res_d.alarm_channel = info_q.rd_ch;
			res_d.read_value    = info_q.rd_val;
		end else begin
			res_d.kind        = tsa_pkg::KIND_MSG;
			res_d.destination = tsa_pkg::FIX_DEST[f];
			if (f == tsa_pkg::STEP_SLOT) begin
				res_d.command = info_q.step_cmd;
			end else begin
				res_d.command = tsa_pkg::FIX_CMD[f];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
		if (pop) begin
			info_q <= job_info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= '0;
			rv_q   <= 1'b0;
		end else begin
			if (advance) begin
				rv_q <= emit;
			end
			if (pop) begin
				busy_q <= 1'b1;
				pend_q <= job_pend;
			end else if (emit) begin
				busy_q <= rest != '0;
				pend_q <= rest;
			end
		end
	end

	assign result_valid = rv_q;
	assign result       = res_q;

endmodule

>>> rtl/core/tick_scheduler_with_timeout_alarms.sv
// Top level of the tick scheduler with timeout alarms.
//
//   channel  valid         stall         payload
//   input    item_valid    item_stall    item   (tsa_pkg::item_t)
//   output   result_valid  result_stall  result (tsa_pkg::result_t)
//
// The front end takes one item per cycle while the two-entry job queue has room.
// The back end delivers one result per cycle unless the output stalls; a tick with
// n results keeps it busy for all n; results pass the queue, pend_q and res_q in turn.
// Reset clears all counters, alarms, dividers and the seconds count at once.
// A stall on the output holds the result register and backs up into the queue.
module tick_scheduler_with_timeout_alarms #(
	parameter int ALARM_CHANNELS = 4,
	parameter int FREE_COUNTERS  = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  tsa_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output tsa_pkg::result_t result
);

	localparam int NS = ALARM_CHANNELS + tsa_pkg::EXTRA_SLOTS;
	localparam int IW = $bits(tsa_pkg::job_info_t);
	localparam int W  = NS + IW;

	logic               full;
	logic               push;
	logic [NS-1:0]      push_pend;
	tsa_pkg::job_info_t push_info;
	logic               pop;
	logic               head_valid;
	logic [W-1:0]       head_data;

	tsa_front #(
		.A  (ALARM_CHANNELS),
		.F  (FREE_COUNTERS),
		.NS (NS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.full       (full),
		.push       (push),
		.push_pend  (push_pend),
		.push_info  (push_info)
	);

	tsa_queue #(
		.W (W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_info, push_pend}),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data),
		.full       (full)
	);

	tsa_back #(
		.A  (ALARM_CHANNELS),
		.NS (NS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (head_valid),
		.job_pend     (head_data[NS-1:0]),
		.job_info     (tsa_pkg::job_info_t'(head_data[W-1:NS])),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> tb/tsa_checker.sv
// Result checker for the tick scheduler: predicts every result and compares each transfer.
`timescale 1ns / 100ps
module tsa_checker #(
	parameter int ALARMS   = 4,
	parameter int COUNTERS = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  tsa_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  tsa_pkg::result_t result,
	output int               mismatches,
	output int               pending,
	output int               delivered,
	output int               expiries,
	output int               peak_burst
);

	localparam int REPORT_LIMIT = 10;

	localparam int PERIOD_HUNDRED       = 100;
	localparam int PERIOD_THREE_HUNDRED = 300;
	localparam int PERIOD_FIVE_HUNDRED  = 500;
	localparam int PERIOD_THOUSAND      = 1000;

	localparam logic [3:0] DEST_TICK     = 4'd1;
	localparam logic [3:0] DEST_THREE_A  = 4'd2;
	localparam logic [3:0] DEST_FIVE_A   = 4'd3;
	localparam logic [3:0] DEST_PERIODIC = 4'd6;
	localparam logic [3:0] DEST_STEP     = 4'd7;
	localparam logic [3:0] DEST_THREE_B  = 4'd8;
	localparam logic [3:0] DEST_FIVE_B   = 4'd10;
	localparam logic [3:0] DEST_SECOND   = 4'd12;
	localparam logic [3:0] DEST_FIVE_C   = 4'd13;

	localparam logic [1:0] CMD_NOTIFY = 2'd0;
	localparam logic [1:0] CMD_POLL   = 2'd1;
	localparam logic [1:0] CMD_WRAP   = 2'd2;

	logic [7:0]  alarm_ticks [ALARMS];
	logic [7:0]  alarm_limit [ALARMS];
	logic        alarm_armed [ALARMS];
	logic [15:0] counter_val [COUNTERS];
	int          div_100, div_300, div_500, div_1000;
	logic [2:0]  step;
	logic [31:0] seconds;
	tsa_pkg::result_t due_results [$];
	tsa_pkg::result_t want;

	function automatic tsa_pkg::result_t outcome(input logic [1:0] kind,
		input logic [3:0] dest, input logic [1:0] cmd, input logic [2:0] chan,
		input logic [31:0] val);
		tsa_pkg::result_t r;
		r.kind = kind;
		r.destination = dest;
		r.command = cmd;
		r.alarm_channel = chan;
		r.read_value = val;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic schedule_item(input tsa_pkg::item_t it);
		tsa_pkg::result_t batch [$];
		tsa_pkg::result_t tail;
		logic [31:0] word;
		case (it.operation)
		tsa_pkg::OP_TICK: begin
			batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_TICK, CMD_NOTIFY, '0, '0));
			for (int i = 0; i < COUNTERS; i++) begin
				if (i >= 1 && i <= 3) counter_val[i] = {8'h00, counter_val[i][7:0] + 8'd1};
				else counter_val[i] = counter_val[i] + 16'd1;
			end
			for (int i = 0; i < ALARMS; i++) begin
				if (alarm_armed[i]) begin
					alarm_ticks[i] = alarm_ticks[i] + 8'd1;
					if (alarm_ticks[i] > alarm_limit[i]) begin
						batch.push_back(outcome(tsa_pkg::KIND_ALARM, '0, '0, 3'(i), '0));
						alarm_armed[i] = 1'b0;
					end
				end
			end
			div_100++;
			if (div_100 >= PERIOD_HUNDRED) begin
				div_100 = 0;
				step = step + 3'd1;
				batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_PERIODIC, CMD_POLL, '0, '0));
				case (step)
				3'd2, 3'd4:
					batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_STEP, CMD_NOTIFY, '0, '0));
				3'd3:
					batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_STEP, CMD_POLL, '0, '0));
				3'd6: begin
					batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_STEP, CMD_WRAP, '0, '0));
					step = '0;
				end
				default: ;
				endcase
			end
			div_300++;
			if (div_300 >= PERIOD_THREE_HUNDRED) begin
				div_300 = 0;
				batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_THREE_A, CMD_NOTIFY, '0, '0));
				batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_THREE_B, CMD_NOTIFY, '0, '0));
			end
			div_500++;
			if (div_500 >= PERIOD_FIVE_HUNDRED) begin
				div_500 = 0;
				batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_FIVE_A, CMD_NOTIFY, '0, '0));
				batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_FIVE_B, CMD_NOTIFY, '0, '0));
				batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_FIVE_C, CMD_NOTIFY, '0, '0));
			end
			div_1000++;
			if (div_1000 >= PERIOD_THOUSAND) begin
				div_1000 = 0;
				seconds = seconds + 32'd1;
				batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_PERIODIC, CMD_NOTIFY, '0, '0));
				batch.push_back(outcome(tsa_pkg::KIND_MSG, DEST_SECOND, CMD_NOTIFY, '0, '0));
			end
		end
		tsa_pkg::OP_ARM: begin
			if (it.channel < ALARMS) begin
				alarm_ticks[it.channel] = '0;
				alarm_limit[it.channel] = it.value[7:0];
				alarm_armed[it.channel] = 1'b1;
			end
		end
		tsa_pkg::OP_DISARM: begin
			if (it.channel < ALARMS) alarm_armed[it.channel] = 1'b0;
		end
		tsa_pkg::OP_LOAD: begin
			if (it.channel < COUNTERS && it.channel != tsa_pkg::SECONDS_CH) begin
				if (it.channel <= 3) counter_val[it.channel] = {8'h00, it.value[7:0]};
				else counter_val[it.channel] = it.value;
			end
		end
		tsa_pkg::OP_READ: begin
			word = '0;
			if (it.channel == tsa_pkg::SECONDS_CH) word = seconds;
			else if (it.channel < COUNTERS) word = {16'h0000, counter_val[it.channel]};
			batch.push_back(outcome(tsa_pkg::KIND_READ, '0, '0, it.channel, word));
		end
		default: ;
		endcase
		if (batch.size() > 0) begin
			tail = batch.pop_back();
			tail.last = 1'b1;
			batch.push_back(tail);
			if (it.operation == tsa_pkg::OP_TICK && batch.size() > peak_burst)
				peak_burst = batch.size();
			foreach (batch[k]) due_results.push_back(batch[k]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALARMS; i++) begin
				alarm_ticks[i] = '0;
				alarm_limit[i] = '0;
				alarm_armed[i] = 1'b0;
			end
			for (int i = 0; i < COUNTERS; i++) counter_val[i] = '0;
			div_100 = 0;
			div_300 = 0;
			div_500 = 0;
			div_1000 = 0;
			step = '0;
			seconds = '0;
			due_results.delete();
			mismatches = 0;
			pending = 0;
			delivered = 0;
			expiries = 0;
			peak_burst = 0;
		end else begin
			if (result_valid && !result_stall) begin
				delivered++;
				if (result.kind == tsa_pkg::KIND_ALARM) expiries++;
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected kind %0d dst %0d cmd %0d ch %0d val %h last %b",
							$time, result.kind, result.destination, result.command,
							result.alarm_channel, result.read_value, result.last);
				end else begin
					want = due_results.pop_front();
					if (result.kind !== want.kind || result.destination !== want.destination ||
						result.command !== want.command ||
						result.alarm_channel !== want.alarm_channel ||
						result.read_value !== want.read_value || result.last !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: #%0d exp kind %0d dst %0d cmd %0d ch %0d val %h last %b",
								$time, delivered, want.kind, want.destination, want.command,
								want.alarm_channel, want.read_value, want.last);
							$display("%0t: #%0d got kind %0d dst %0d cmd %0d ch %0d val %h last %b",
								$time, delivered, result.kind, result.destination,
								result.command, result.alarm_channel, result.read_value,
								result.last);
						end
					end
				end
			end
			if (item_valid && !item_stall) schedule_item(item);
			pending = due_results.size();
		end
	end

endmodule

>>> tb/tick_scheduler_with_timeout_alarms_test.sv
// Test top for the tick scheduler: clock, reset, item stimulus, result stall and verdict.
`timescale 1ns / 100ps
module tick_scheduler_with_timeout_alarms_test;

	localparam int ALARMS         = 4;
	localparam int COUNTERS       = 6;
	localparam int ITEM_TARGET    = 300;
	localparam int ALARM_FLOOD    = 100;
	localparam int MAX_GAP        = 14;
	localparam int HOLD_OFF       = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 24;

	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
	localparam logic [2:0] ALARM_CAN       = 3'd3;
	localparam logic [2:0] NO_CHANNEL      = 3'd7;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	tsa_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	tsa_pkg::result_t result;

	int mismatches, pending, delivered, expiries, peak_burst;
	int sent = 0;
	int ticks = 0;
	int sender_calm = 0;
	int receiver_calm = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tick_scheduler_with_timeout_alarms #(
		.ALARM_CHANNELS(ALARMS),
		.FREE_COUNTERS(COUNTERS)
	) u_top (.*);

	tsa_checker #(
		.ALARMS(ALARMS),
		.COUNTERS(COUNTERS)
	) u_checker (.*);

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) calm = $urandom_range(8, 40);
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic tsa_pkg::item_t make_item(input logic [2:0] op, input logic [2:0] ch,
		input logic [15:0] val);
		tsa_pkg::item_t it;
		it.operation = op;
		it.channel = ch;
		it.value = val;
		return it;
	endfunction

	function automatic tsa_pkg::item_t random_item();
		tsa_pkg::item_t it;
		int roll;
		roll = $urandom_range(0, 99);
		it.channel = 3'($urandom);
		it.value = 16'($urandom);
		if (roll < 66) begin
			it.operation = tsa_pkg::OP_TICK;
		end else if (roll < 78) begin
			it.operation = tsa_pkg::OP_ARM;
			if ($urandom_range(0, 3) != 0) it.channel = 3'($urandom_range(0, ALARMS - 1));
			case ($urandom_range(0, 3))
			0: it.value[7:0] = 8'hFF;
			1, 2: it.value[7:0] = 8'($urandom_range(0, 12));
			default: ;
			endcase
		end else if (roll < 84) begin
			it.operation = tsa_pkg::OP_DISARM;
			if ($urandom_range(0, 3) != 0) it.channel = 3'($urandom_range(0, ALARMS - 1));
		end else if (roll < 91) begin
			it.operation = tsa_pkg::OP_LOAD;
		end else if (roll < 98) begin
			it.operation = tsa_pkg::OP_READ;
		end else begin
			it.operation = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
		end
		return it;
	endfunction

	task automatic send_item(input tsa_pkg::item_t it);
		int gap;
		gap = draw_gap(sender_calm);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
		if (it.operation == tsa_pkg::OP_TICK) ticks++;
	endtask

	// The receiver holds off twice for a long stretch so that the block backs up.
	initial begin : receiver
		int hold;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			hold = (taken == 40 || taken == 150) ? HOLD_OFF : draw_gap(receiver_calm);
			if (hold > 0) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				result_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(result_valid && !result_stall)) @(posedge clk);
			taken++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
			else quiet++;
		end
		$display("Timed out: no transfer for %0d cycles, %0d results still awaited",
			quiet, pending);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int flood_mark;
		flood_mark = -1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(make_item(tsa_pkg::OP_READ, tsa_pkg::SECONDS_CH, 16'hFFFF));
		send_item(make_item(tsa_pkg::OP_READ, NO_CHANNEL, 16'h0000));
		send_item(make_item(tsa_pkg::OP_LOAD, 3'd0, 16'hFFFF));
		send_item(make_item(tsa_pkg::OP_LOAD, 3'd1, 16'hABFF));
		send_item(make_item(tsa_pkg::OP_LOAD, 3'd4, 16'hFFFF));
		send_item(make_item(tsa_pkg::OP_LOAD, tsa_pkg::SECONDS_CH, 16'h1234));
		send_item(make_item(tsa_pkg::OP_LOAD, NO_CHANNEL, 16'hFFFF));
		send_item(make_item(tsa_pkg::OP_ARM, 3'd0, 16'hFF00));
		send_item(make_item(tsa_pkg::OP_ARM, 3'd1, 16'h00FF));
		send_item(make_item(tsa_pkg::OP_ARM, 3'd2, 16'h5501));
		send_item(make_item(tsa_pkg::OP_ARM, ALARM_CAN, 16'h0002));
		send_item(make_item(tsa_pkg::OP_DISARM, ALARM_CAN, 16'h0000));
		send_item(make_item(tsa_pkg::OP_ARM, NO_CHANNEL, 16'h0000));
		send_item(make_item(tsa_pkg::OP_DISARM, 3'd5, 16'hFFFF));
		send_item(make_item(tsa_pkg::OP_ARM, 3'd2, 16'h0001));
		for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
			send_item(make_item(3'(op), 3'd0, 16'h0000));
		repeat (3) send_item(make_item(tsa_pkg::OP_TICK, 3'd0, 16'h0000));
		send_item(make_item(tsa_pkg::OP_READ, 3'd0, 16'h0000));
		send_item(make_item(tsa_pkg::OP_READ, 3'd1, 16'h0000));
		send_item(make_item(tsa_pkg::OP_READ, 3'd4, 16'h0000));
		send_item(make_item(tsa_pkg::OP_READ, 3'd5, 16'h0000));

		// Ahead of every 100th tick all alarms are armed to expire together with the divider.
		while (sent < ITEM_TARGET) begin
			if (ticks % ALARM_FLOOD == ALARM_FLOOD - 1 && flood_mark != ticks) begin
				flood_mark = ticks;
				for (int a = 0; a < ALARMS; a++)
					send_item(make_item(tsa_pkg::OP_ARM, 3'(a), 16'($urandom) & 16'hFF00));
				send_item(make_item(tsa_pkg::OP_TICK, 3'($urandom), 16'($urandom)));
			end else begin
				send_item(random_item());
			end
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d items with %0d ticks, %0d results, %0d alarm expiries.",
			sent, ticks, delivered, expiries);
		$display("Busiest tick gave %0d results; %0d errors, %0d results left awaited.",
			peak_burst, mismatches, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
